FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the IMU frame parser.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while in reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked implication, off while in reset.
`define ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

FILE: hw/rtl/imu_fp_pkg.sv
// Types and constants of the IMU frame parser.
// No dependencies; imported by every module of the block.
package imu_fp_pkg;

  localparam int unsigned FRAME_LEN = 11;
  localparam int unsigned CNT_W     = $clog2(FRAME_LEN);

  localparam logic [7:0] HDR_BYTE  = 8'h55;
  localparam logic [7:0] TYPE_ACC  = 8'h51;
  localparam logic [7:0] TYPE_GYR  = 8'h52;
  localparam logic [7:0] TYPE_ANG  = 8'h53;

  typedef enum logic [1:0] {
    KIND_ACC = 2'd0,
    KIND_GYR = 2'd1,
    KIND_ANG = 2'd2
  } frame_kind_e;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             done;
    logic [7:0]       type_byte;
    logic [3:0][15:0] words;
  } coll_t;

  typedef struct packed {
    logic               known;
    frame_kind_e        kind;
    logic signed [15:0] word_a;
    logic signed [15:0] word_b;
    logic signed [15:0] word_c;
    logic signed [15:0] word_d;
    logic signed [8:0]  pitch;
    logic signed [8:0]  roll;
    logic signed [8:0]  yaw;
    logic signed [22:0] rate;
  } res_t;

endpackage

FILE: hw/rtl/imu_fp_collect.sv
// Byte counter and frame store of the IMU frame parser.
// Depends on imu_fp_pkg.
module imu_fp_collect import imu_fp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output coll_t      coll_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       frame_q [FRAME_LEN-1];
  logic             last;

  assign last = (count_q >= CNT_W'(FRAME_LEN - 1));

  always_comb begin
    count_d = count_q;
    if (accept_i) begin
      if (count_q == '0 && rx_byte_i != HDR_BYTE) begin
        count_d = '0;
      end else if (last) begin
        count_d = '0;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !last) begin
      frame_q[count_q] <= rx_byte_i;
    end
  end

  always_comb begin
    coll_o.count     = count_q;
    coll_o.done      = accept_i && last;
    coll_o.type_byte = frame_q[1];
    coll_o.words[0]  = {frame_q[3], frame_q[2]};
    coll_o.words[1]  = {frame_q[5], frame_q[4]};
    coll_o.words[2]  = {frame_q[7], frame_q[6]};
    coll_o.words[3]  = {frame_q[9], frame_q[8]};
  end

endmodule

FILE: hw/rtl/imu_fp_convert.sv
// Frame type decode and angle and rate scaling of the IMU frame parser.
// Depends on imu_fp_pkg.
module imu_fp_convert import imu_fp_pkg::*; (
  input  coll_t coll_i,
  output res_t  res_o
);

  function automatic logic signed [8:0] neg_deg(input logic signed [15:0] w);
    logic signed [23:0] p;
    logic signed [23:0] t;
    logic signed [9:0]  q;
    p = 24'($signed(w)) * 24'sd180;
    t = p + (p[23] ? 24'sd32767 : 24'sd0);
    q = 10'(t >>> 15);
    return 9'(-q);
  endfunction

  logic signed [23:0] rate_full;

  assign rate_full = -(24'($signed(coll_i.words[2])) * 24'sd125);

  always_comb begin
    res_o.known  = 1'b1;
    res_o.kind   = KIND_ACC;
    case (coll_i.type_byte)
      TYPE_ACC: res_o.kind = KIND_ACC;
      TYPE_GYR: res_o.kind = KIND_GYR;
      TYPE_ANG: res_o.kind = KIND_ANG;
      default:  res_o.known = 1'b0;
    endcase
    res_o.word_a = coll_i.words[0];
    res_o.word_b = coll_i.words[1];
    res_o.word_c = coll_i.words[2];
    res_o.word_d = coll_i.words[3];
    res_o.pitch  = neg_deg(coll_i.words[0]);
    res_o.roll   = neg_deg(coll_i.words[1]);
    res_o.yaw    = neg_deg(coll_i.words[2]);
    res_o.rate   = rate_full[22:0];
  end

endmodule

FILE: hw/rtl/imu_frame_parser.sv
// Channel  | Dir | Handshake             | Payload
// input    | in  | in_valid_i/in_stall_o | rx_byte_i
// result   | out | out_valid_o/out_stall_i | frame_kind_o, word_*_o, *_deg_o, yaw_rate_o
// One byte is taken per cycle unless stalled; a result of a known frame type appears in
// the cycle after its last byte. Byte store and counter feed the scaling logic, which
// loads the result register. Reset clears the byte counter, held angles, held rate and
// the result valid. The final byte of a frame is stalled only while an untaken result
// blocks the register. Top level of the IMU frame parser; depends on imu_fp_pkg,
// imu_fp_collect, imu_fp_convert and assert_macros.svh.
`include "assert_macros.svh"
module imu_frame_parser import imu_fp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         frame_kind_o,
  output logic signed [15:0] word_a_o,
  output logic signed [15:0] word_b_o,
  output logic signed [15:0] word_c_o,
  output logic signed [15:0] word_d_o,
  output logic signed [8:0]  roll_deg_o,
  output logic signed [8:0]  pitch_deg_o,
  output logic signed [8:0]  yaw_deg_o,
  output logic signed [22:0] yaw_rate_o
);

  coll_t coll;
  res_t  res;
  logic  in_accept;
  logic  load;

  logic signed [8:0]  roll_q, roll_d, pitch_q, pitch_d, yaw_q, yaw_d;
  logic signed [22:0] rate_q, rate_d;
  logic               out_valid_q, out_valid_d;
  res_t               out_q;
  logic signed [8:0]  out_roll_q, out_pitch_q, out_yaw_q;
  logic signed [22:0] out_rate_q;

  assign in_stall_o = out_valid_q && out_stall_i &&
                      (coll.count >= CNT_W'(FRAME_LEN - 1));
  assign in_accept  = in_valid_i && !in_stall_o;

  imu_fp_collect u_collect (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .rx_byte_i (rx_byte_i),
    .coll_o    (coll)
  );

  imu_fp_convert u_convert (
    .coll_i (coll),
    .res_o  (res)
  );

  assign load = coll.done && res.known;

  always_comb begin
    roll_d  = roll_q;
    pitch_d = pitch_q;
    yaw_d   = yaw_q;
    rate_d  = rate_q;
    if (load && res.kind == KIND_ANG) begin
      roll_d  = res.roll;
      pitch_d = res.pitch;
      yaw_d   = res.yaw;
    end
    if (load && res.kind == KIND_GYR) begin
      rate_d = res.rate;
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_q      <= '0;
      pitch_q     <= '0;
      yaw_q       <= '0;
      rate_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      roll_q      <= roll_d;
      pitch_q     <= pitch_d;
      yaw_q       <= yaw_d;
      rate_q      <= rate_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q       <= res;
      out_roll_q  <= roll_d;
      out_pitch_q <= pitch_d;
      out_yaw_q   <= yaw_d;
      out_rate_q  <= rate_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_kind_o = out_q.kind;
  assign word_a_o     = out_q.word_a;
  assign word_b_o     = out_q.word_b;
  assign word_c_o     = out_q.word_c;
  assign word_d_o     = out_q.word_d;
  assign roll_deg_o   = out_roll_q;
  assign pitch_deg_o  = out_pitch_q;
  assign yaw_deg_o    = out_yaw_q;
  assign yaw_rate_o   = out_rate_q;

  `ASSERT_CLK(a_count_range, coll.count <= CNT_W'(FRAME_LEN - 1), "byte count out of range")
  `ASSERT_IMPL(a_stall_needs_result, in_stall_o, out_valid_o, "input stalled without result")
  `ASSERT_IMPL(a_bad_header, in_accept && coll.count == '0 && rx_byte_i != HDR_BYTE,
    ##1 coll.count == '0, "non-header byte started a frame")
  `ASSERT_CLK(a_result_source, $rose(out_valid_o) |-> $past(in_accept),
    "result without an input transfer")

endmodule

FILE: tb/tb_imu_frame_parser.sv
// Testbench for imu_frame_parser: feeds serial byte streams of whole, broken and unknown frames
// and checks every frame result field by field against a built-in frame predictor.
// Depends on imu_fp_pkg and the imu_frame_parser RTL.
import imu_fp_pkg::*;

typedef struct {
  logic [1:0]         kind;
  logic signed [15:0] word_a;
  logic signed [15:0] word_b;
  logic signed [15:0] word_c;
  logic signed [15:0] word_d;
  logic signed [8:0]  roll;
  logic signed [8:0]  pitch;
  logic signed [8:0]  yaw;
  logic signed [22:0] rate;
} frame_result_t;

class frame_scoreboard;
  frame_result_t      expected_q[$];
  logic [7:0]         frame_buf[FRAME_LEN-1];
  int unsigned        fill;
  logic signed [8:0]  roll;
  logic signed [8:0]  pitch;
  logic signed [8:0]  yaw;
  logic signed [22:0] rate;
  int                 errors;

  function new();
    fill   = 0;
    roll   = 0;
    pitch  = 0;
    yaw    = 0;
    rate   = 0;
    errors = 0;
  endfunction

  function void report(string what);
    $display("ERROR: %s", what);
    errors++;
  endfunction

  function logic signed [8:0] to_deg(logic signed [15:0] w);
    int prod;
    prod = int'(w) * 180;
    return 9'(-(prod / 32768));
  endfunction

  // Returns 0 for a byte the parser drops while hunting for a header.
  function bit note_byte(logic [7:0] b);
    frame_result_t      r;
    logic signed [15:0] w[4];
    if (fill == 0 && b != HDR_BYTE) return 0;
    if (fill < FRAME_LEN - 1) begin
      frame_buf[fill] = b;
      fill++;
      return 1;
    end
    fill = 0;
    case (frame_buf[1])
      TYPE_ACC: r.kind = KIND_ACC;
      TYPE_GYR: r.kind = KIND_GYR;
      TYPE_ANG: r.kind = KIND_ANG;
      default: return 1;
    endcase
    for (int i = 0; i < 4; i++) begin
      w[i] = {frame_buf[2*i+3], frame_buf[2*i+2]};
    end
    if (r.kind == KIND_GYR) begin
      rate = 23'(-(int'(w[2]) * 125));
    end else if (r.kind == KIND_ANG) begin
      pitch = to_deg(w[0]);
      roll  = to_deg(w[1]);
      yaw   = to_deg(w[2]);
    end
    r.word_a = w[0];
    r.word_b = w[1];
    r.word_c = w[2];
    r.word_d = w[3];
    r.roll   = roll;
    r.pitch  = pitch;
    r.yaw    = yaw;
    r.rate   = rate;
    expected_q.push_back(r);
    return 1;
  endfunction

  function void compare(string name, logic signed [31:0] got, logic signed [31:0] want);
    if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
  endfunction

  function void check_result(frame_result_t got);
    frame_result_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("result of kind %0d with no frame pending", got.kind));
      return;
    end
    want = expected_q.pop_front();
    compare("frame_kind", {30'd0, got.kind}, {30'd0, want.kind});
    compare("word_a", got.word_a, want.word_a);
    compare("word_b", got.word_b, want.word_b);
    compare("word_c", got.word_c, want.word_c);
    compare("word_d", got.word_d, want.word_d);
    compare("roll_deg", got.roll, want.roll);
    compare("pitch_deg", got.pitch, want.pitch);
    compare("yaw_deg", got.yaw, want.yaw);
    compare("yaw_rate", got.rate, want.rate);
  endfunction
endclass

module tb_imu_frame_parser;
  localparam int IDLE_LIMIT  = 4000;
  localparam int LONG_HOLD   = 300;
  localparam int BYTE_TARGET = 1550;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         frame_kind_o;
  logic signed [15:0] word_a_o;
  logic signed [15:0] word_b_o;
  logic signed [15:0] word_c_o;
  logic signed [15:0] word_d_o;
  logic signed [8:0]  roll_deg_o;
  logic signed [8:0]  pitch_deg_o;
  logic signed [8:0]  yaw_deg_o;
  logic signed [22:0] yaw_rate_o;

  frame_scoreboard sb;
  bit              hold_req;
  bit              no_gaps;
  int              consumed;
  int              idle_cycles;

  imu_frame_parser i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .frame_kind_o(frame_kind_o),
    .word_a_o    (word_a_o),
    .word_b_o    (word_b_o),
    .word_c_o    (word_c_o),
    .word_d_o    (word_d_o),
    .roll_deg_o  (roll_deg_o),
    .pitch_deg_o (pitch_deg_o),
    .yaw_deg_o   (yaw_deg_o),
    .yaw_rate_o  (yaw_rate_o)
  );

  always #5 clk_i = ~clk_i;

  function int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b, int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (sb.note_byte(b)) consumed++;
  endtask

  task automatic send_frame(logic [7:0] type_byte, logic [15:0] wa, logic [15:0] wb,
                            logic [15:0] wc, logic [15:0] wd, logic [7:0] csum);
    logic [7:0] seq[FRAME_LEN];
    seq = '{HDR_BYTE, type_byte, wa[7:0], wa[15:8], wb[7:0], wb[15:8],
            wc[7:0], wc[15:8], wd[7:0], wd[15:8], csum};
    foreach (seq[i]) send_byte(seq[i], pick_gap());
  endtask

  task automatic send_random_frame(logic [7:0] type_byte);
    send_frame(type_byte, pick_word(), pick_word(), pick_word(), pick_word(),
               8'($urandom));
  endtask

  task automatic rest();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Watchdog: cycles without any transfer on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    frame_result_t got;
    int            run_left;
    bit            run_stall;
    bit            hold_taken;
    int            r;
    out_stall_i = 1'b0;
    run_left    = 0;
    run_stall   = 1'b0;
    hold_taken  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.kind   = frame_kind_o;
        got.word_a = word_a_o;
        got.word_b = word_b_o;
        got.word_c = word_c_o;
        got.word_d = word_d_o;
        got.roll   = roll_deg_o;
        got.pitch  = pitch_deg_o;
        got.yaw    = yaw_deg_o;
        got.rate   = yaw_rate_o;
        sb.check_result(got);
      end
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        run_stall  = 1'b1;
        run_left   = LONG_HOLD;
        hold_taken = 1'b1;
      end else if (run_left <= 0) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          run_stall = 1'b0;
          run_left  = $urandom_range(1, 4);
        end else if (r < 80) begin
          run_stall = 1'b1;
          run_left  = $urandom_range(1, 3);
        end else if (r < 92) begin
          run_stall = 1'b0;
          run_left  = $urandom_range(20, 60);
        end else begin
          run_stall = 1'b1;
          run_left  = $urandom_range(10, 40);
        end
      end
      out_stall_i <= run_stall;
      run_left--;
    end
  end

  initial begin
    int r;
    bit drained_once;
    sb           = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    rx_byte_i    = 8'h00;
    hold_req     = 1'b0;
    no_gaps      = 1'b0;
    consumed     = 0;
    drained_once = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_byte(8'h00, 0);
    send_byte(8'hff, 0);
    send_byte(8'haa, 1);
    send_frame(TYPE_ACC, 16'h8000, 16'h7fff, 16'h0000, 16'hffff, 8'h00);
    send_frame(TYPE_GYR, 16'h1234, 16'hedcb, 16'h8000, 16'h0100, 8'hff);
    send_frame(TYPE_ANG, 16'h8000, 16'h7fff, 16'hffff, 16'h0100, 8'h5a);
    send_frame(HDR_BYTE, 16'h0001, 16'h8001, 16'h7ffe, 16'h0000, 8'h55);

    hold_req = 1'b1;
    while (consumed < BYTE_TARGET) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        case ($urandom_range(0, 2))
          0: send_random_frame(TYPE_ACC);
          1: send_random_frame(TYPE_GYR);
          default: send_random_frame(TYPE_ANG);
        endcase
      end else if (r < 78) begin
        send_random_frame(8'($urandom));
      end else if (r < 88) begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom), pick_gap());
      end else begin
        send_byte(HDR_BYTE, pick_gap());
        repeat ($urandom_range(0, 8)) send_byte(8'($urandom), pick_gap());
      end
      if (!drained_once && consumed > BYTE_TARGET / 2) begin
        rest();
        wait_drained();
        drained_once = 1'b1;
      end
    end

    rest();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.expected_q.size() != 0) sb.report("frame results still pending at end of run");
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
